### rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int WORD_W       = 32;
  localparam int FILL_W       = 5;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_REAR   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    status_t                  status;
    logic [FILL_W-1:0]        fill;
  } rsp_t;

  // per-cycle command broadcast to every cell, already qualified
  typedef struct packed {
    logic push_rear;
    logic push_front;
    logic pop_rear;
    logic pop_front;
  } cell_cmd_t;

endpackage

### rtl/dq_cell.sv
// one storage cell of the shifting deque chain
module dq_cell import dq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_cmd_t                 cmd,
  input  logic signed [WORD_W-1:0]  push_word,
  input  logic signed [WORD_W-1:0]  left_data,
  input  logic                      left_valid,
  input  logic signed [WORD_W-1:0]  right_data,
  input  logic                      right_valid,
  output logic signed [WORD_W-1:0]  data,
  output logic                      valid,
  output logic                      is_rear
);

  // this cell holds the last element of the queue
  assign is_rear = valid && !right_valid;

  // occupancy bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.push_front) begin
      valid <= left_valid;
    end else if (cmd.pop_front) begin
      valid <= right_valid;
    end else if (cmd.push_rear && !valid && left_valid) begin
      valid <= 1'b1;
    end else if (cmd.pop_rear && is_rear) begin
      valid <= 1'b0;
    end
  end

  // element word, shifted from a neighbor or loaded at the rear
  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      data <= left_data;
    end else if (cmd.pop_front) begin
      data <= right_data;
    end else if (cmd.push_rear && !valid && left_valid) begin
      data <= push_word;
    end
  end

endmodule

### rtl/double_ended_queue.sv
// bounded deque built as a row of shifting cells, front element in cell 0
// the response is registered and appears in the cycle after the request is accepted
// throughput: one request per cycle while the response is taken; each cell shifts or loads in a single step
// the rear pop selects the last occupied cell through a one-hot OR over the row
// reset: synchronous, clears all cell valid bits, the count and the response flag
module double_ended_queue import dq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0]        valid;
  logic [CAPACITY-1:0]        rear;
  logic signed [WORD_W-1:0]   data [CAPACITY];
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W+FILL_W-1:0]    count_ext;
  logic                       fire;
  logic                       full;
  logic                       empty;
  cell_cmd_t                  cmd;
  logic signed [WORD_W-1:0]   rear_word;
  rsp_t                       rsp_next;

  // handshake
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign full      = valid[CAPACITY-1];
  assign empty     = !valid[0];

  // qualified command for the cells
  always_comb begin
    cmd            = '0;
    cmd.push_rear  = fire && (req.op == OP_PUSH_REAR)  && !full;
    cmd.push_front = fire && (req.op == OP_PUSH_FRONT) && !full;
    cmd.pop_rear   = fire && (req.op == OP_POP_REAR)   && !empty;
    cmd.pop_front  = fire && (req.op == OP_POP_FRONT)  && !empty;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_data;
    logic                     left_valid;
    logic signed [WORD_W-1:0] right_data;
    logic                     right_valid;

    if (i == 0) begin : g_head
      assign left_data  = req.value;
      assign left_valid = 1'b1;
    end else begin : g_body
      assign left_data  = data[i-1];
      assign left_valid = valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_data  = data[i+1];
      assign right_valid = valid[i+1];
    end

    dq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_word   (req.value),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (data[i]),
      .valid       (valid[i]),
      .is_rear     (rear[i])
    );
  end

  // rear element select, rear is one-hot or empty
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rear_word = rear_word | (data[i] & {WORD_W{rear[i]}});
    end
  end

  // element count
  always_comb begin
    count_next = count;
    if (cmd.push_rear || cmd.push_front) begin
      count_next = count + 1'b1;
    end else if (cmd.pop_rear || cmd.pop_front) begin
      count_next = count - 1'b1;
    end
  end

  assign count_ext = {{FILL_W{1'b0}}, count_next};

  // response word
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = ST_DONE;
    rsp_next.fill   = count_ext[FILL_W-1:0];
    case (req.op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
          rsp_next.popped = '1;
        end else begin
          rsp_next.popped = rear_word;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
          rsp_next.popped = '1;
        end else begin
          rsp_next.popped = data[0];
        end
      end
      default: begin
        rsp_next.status = ST_DONE;
      end
    endcase
  end

  // count and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // occupied cells always match the count
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("cell occupancy disagrees with count");

  // at most one cell claims to be the rear
  a_rear_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rear))
    else $error("more than one rear cell");

  // a push onto a full row is refused
  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (fire && full && !req.op[1]) |=> (rsp.status == ST_FULL && $stable(valid)))
    else $error("push onto full queue not refused");

  // a pop from an empty row answers minus one
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (fire && empty && req.op[1]) |=> (rsp.status == ST_EMPTY && rsp.popped == '1))
    else $error("empty pop answered wrongly");
`endif

endmodule
